// File: sv/kmsd_pkg.sv
// ----------------------------------------------------------------------------
// kmsd_pkg: shared types of the key matrix scanner
// Request, configuration, key state and event codes used by the front end, engine and top.
// ----------------------------------------------------------------------------
package kmsd_pkg;

  // request codes carried in the op field
  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLICK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // event kinds; the low two bits go into a queue entry
  typedef enum logic [2:0] {
    EV_DOWN = 3'd0,
    EV_UP   = 3'd1,
    EV_FALL = 3'd2,
    EV_RISE = 3'd3,
    EV_NONE = 3'd4
  } ev_kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_UP   = 2'd0;
  localparam logic [1:0] REG_MAX_UP   = 2'd1;
  localparam logic [1:0] REG_MIN_DOWN = 2'd2;
  localparam logic [1:0] REG_EV_MASK  = 2'd3;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] min_up;
    logic [15:0] max_up;
    logic [15:0] min_down;
    logic [3:0]  ev_mask;
  } cfg_t;

  // classified request from the front end
  typedef struct packed {
    op_t        op;
    logic [7:0] levels;
  } req_t;

  // stored state of one key
  typedef struct packed {
    logic        down;
    logic [15:0] rel_cnt;
    logic [15:0] prs_cnt;
    ev_kind_t    last;
  } kst_t;

  // result handed to the output stage
  typedef struct packed {
    logic       found;
    logic [5:0] key;
    logic [3:0] queued;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_QRD1,
    BK_QRD2,
    BK_QEVAL,
    BK_DONE
  } bk_state_t;

endpackage

// File: sv/kmsd_ram.sv
// ----------------------------------------------------------------------------
// kmsd_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/kmsd_front.sv
// ----------------------------------------------------------------------------
// kmsd_front: request intake
// Accepts requests, decodes the op code and holds them in a two entry queue.
// ----------------------------------------------------------------------------
module kmsd_front import kmsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_levels,
  output logic       req_valid,
  output req_t       req,
  input  logic       req_pop
);

  req_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  req_t       dec;

  // classify the incoming op
  always_comb begin
    dec.levels = in_levels;
    unique case (in_op)
      OP_SCAN:  dec.op = OP_SCAN;
      OP_CHECK: dec.op = OP_CHECK;
      OP_CLICK: dec.op = OP_CLICK;
      default:  dec.op = OP_NONE;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign req_valid = (cnt_r != 2'd0);
  assign req       = slot_r[rp_r];

  // pointer and fill updates
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = req_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, req_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= dec;
    end
  end

endmodule

// File: sv/kmsd_back.sv
// ----------------------------------------------------------------------------
// kmsd_back: scan and query engine
// Debounces one key per cycle from the key state memory and runs the event
// queue; answers check and click queries from the queue memory.
// ----------------------------------------------------------------------------
module kmsd_back import kmsd_pkg::*; #(
  parameter int ROWS        = 8,
  parameter int COLS        = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic req_valid,
  input  req_t req,
  output logic req_pop,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);

  localparam int NKEYS = ROWS * COLS;
  localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int EW    = KW + 2;

  bk_state_t state_r, state_nxt;

  logic [CW-1:0] col_r;
  logic [KW-1:0] base_r;
  logic [7:0]    levels_r;
  op_t           op_r;
  logic [PW-1:0] wptr_r, rptr_r;
  logic [NKEYS-1:0] kvalid_r;

  // process stage of the scan pipeline
  logic          p_v_r;
  logic [KW-1:0] p_key_r;
  logic          p_pressed_r;
  logic          p_valid_r;

  logic [EW-1:0] e1_r;
  logic          found_r;
  logic [KW-1:0] key_r;

  // control outputs
  logic          issue;
  logic          last_col;

  // memory ports
  logic [KW-1:0] k_raddr;
  kst_t          k_rdata, k_wdata;
  logic          q_we;
  logic [EW-1:0] q_wdata, q_rdata;
  logic [PW-1:0] q_raddr;

  // ---------------------------------------------------------------- helpers
  function automatic logic [PW-1:0] nxt_slot(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  logic [PW:0]   diff;
  logic [PW-1:0] qcnt;
  logic          qfull;

  assign diff  = {1'b0, wptr_r} - {1'b0, rptr_r};
  assign qcnt  = diff[PW] ? PW'(diff + (PW + 1)'(QUEUE_DEPTH)) : diff[PW-1:0];
  assign qfull = (qcnt == PW'(QUEUE_DEPTH - 1));

  assign last_col = (col_r == CW'(COLS - 1));

  // ---------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (req_valid) begin
          unique case (req.op)
            OP_SCAN:  state_nxt = BK_SCAN;
            OP_CHECK: state_nxt = BK_QRD1;
            OP_CLICK: state_nxt = BK_QRD1;
            OP_NONE:  state_nxt = BK_DONE;
          endcase
        end
      end
      BK_SCAN:  if (last_col) state_nxt = BK_DRAIN;
      BK_DRAIN: state_nxt = BK_DONE;
      BK_QRD1:  state_nxt = BK_QRD2;
      BK_QRD2:  state_nxt = (op_r == OP_CLICK) ? BK_QEVAL : BK_DONE;
      BK_QEVAL: state_nxt = BK_DONE;
      BK_DONE:  if (res_ready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    req_pop   = 1'b0;
    issue     = 1'b0;
    res_valid = 1'b0;
    q_raddr   = rptr_r;
    unique case (state_r)
      BK_IDLE:  req_pop = req_valid;
      BK_SCAN:  issue = 1'b1;
      BK_QRD2:  q_raddr = nxt_slot(rptr_r);
      BK_DONE:  res_valid = 1'b1;
      default:  ;
    endcase
  end

  assign k_raddr = base_r + KW'(col_r);

  // ------------------------------------------------------- key debounce
  kst_t     ks;
  logic     cand;
  ev_kind_t kind;
  logic     post;

  always_comb begin
    if (p_valid_r) begin
      ks = k_rdata;
    end else begin
      ks.down    = 1'b0;
      ks.rel_cnt = '0;
      ks.prs_cnt = '0;
      ks.last    = EV_NONE;
    end
    k_wdata = ks;
    cand    = 1'b0;
    kind    = EV_DOWN;
    if (p_pressed_r) begin
      if (ks.down) begin
        if (ks.prs_cnt != CNT_MAX) k_wdata.prs_cnt = ks.prs_cnt + 16'd1;
        cand = (k_wdata.prs_cnt >= cfg.min_down);
        kind = EV_DOWN;
      end else begin
        k_wdata.down = 1'b1;
        kind         = EV_FALL;
        if (ks.rel_cnt >= cfg.min_up) cand = 1'b1;
        else k_wdata.rel_cnt = '0;
      end
    end else begin
      if (!ks.down) begin
        if (ks.rel_cnt < cfg.max_up) k_wdata.rel_cnt = ks.rel_cnt + 16'd1;
        cand = (k_wdata.rel_cnt >= cfg.min_up);
        kind = EV_UP;
      end else begin
        k_wdata.down = 1'b0;
        kind         = EV_RISE;
        if (ks.prs_cnt >= cfg.min_down) cand = 1'b1;
        else k_wdata.prs_cnt = '0;
      end
    end
    post = p_v_r && cand && cfg.ev_mask[kind[1:0]] && (ks.last != kind);
    if (post) k_wdata.last = kind;
  end

  assign q_we    = post;
  assign q_wdata = {p_key_r, kind[1:0]};

  // ------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      wptr_r   <= '0;
      rptr_r   <= '0;
      base_r   <= '0;
      kvalid_r <= '0;
      p_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_v_r   <= issue;
      if (p_v_r) kvalid_r[p_key_r] <= 1'b1;
      // queue pointers: new event, drop of oldest, click pop
      if (post) begin
        wptr_r <= nxt_slot(wptr_r);
        if (qfull) rptr_r <= nxt_slot(rptr_r);
      end else if (state_r == BK_QEVAL && qcnt >= PW'(2)) begin
        rptr_r <= nxt_slot(nxt_slot(rptr_r));
      end
      // next row once the last key is processed
      if (state_r == BK_DRAIN) begin
        if (base_r == KW'(NKEYS - COLS)) base_r <= '0;
        else base_r <= base_r + KW'(COLS);
      end
    end
  end

  // ---------------------------------------------------------- datapath
  logic [CW+3:0] colx;
  assign colx = {4'b0, col_r};

  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE) begin
      col_r    <= '0;
      op_r     <= req.op;
      levels_r <= req.levels;
      found_r  <= 1'b0;
      key_r    <= '0;
    end
    if (issue) begin
      col_r       <= col_r + 1'b1;
      p_key_r     <= k_raddr;
      p_pressed_r <= (colx < (CW + 4)'(8)) && levels_r[colx[2:0]];
      p_valid_r   <= kvalid_r[k_raddr];
    end
    if (state_r == BK_QRD2) begin
      e1_r <= q_rdata;
      if (op_r == OP_CHECK && qcnt == PW'(1) && q_rdata[1:0] == EV_DOWN[1:0]) begin
        found_r <= 1'b1;
        key_r   <= q_rdata[EW-1:2];
      end
    end
    if (state_r == BK_QEVAL) begin
      if (qcnt >= PW'(2) && e1_r[EW-1:2] == q_rdata[EW-1:2] &&
          e1_r[1:0] == EV_DOWN[1:0] && q_rdata[1:0] == EV_UP[1:0]) begin
        found_r <= 1'b1;
        key_r   <= e1_r[EW-1:2];
      end
    end
  end

  // result fields, cut or padded to their port widths
  logic [KW+5:0] keyx;
  logic [PW+3:0] cntx;
  assign keyx       = {6'b0, key_r};
  assign cntx       = {4'b0, qcnt};
  assign res.found  = found_r;
  assign res.key    = keyx[5:0];
  assign res.queued = cntx[3:0];

  // -------------------------------------------------------------- memories
  kmsd_ram #(.WIDTH($bits(kst_t)), .DEPTH(NKEYS)) u_key_ram (
    .clk   (clk),
    .we    (p_v_r),
    .waddr (p_key_r),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  kmsd_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_evq_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (wptr_r),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

`ifndef ASSERT_OFF
  // a key is processed only right after it was read during a scan
  a_proc_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> $past(state_r) == BK_SCAN)
    else $error("key processed outside a scan");

  // queries never write the event queue
  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_QRD1 || state_r == BK_QRD2 || state_r == BK_QEVAL) |-> !q_we)
    else $error("queue written during a query");

  // a taken result frees the engine
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DONE && res_ready) |=> state_r == BK_IDLE)
    else $error("engine held after result taken");

  // a request is taken only when idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_pop |-> (state_r == BK_IDLE && req_valid))
    else $error("request taken while busy");
`endif

endmodule

// File: sv/key_matrix_scan_debounce_events_top.sv
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce_events_top: key matrix scanner with debounce
// Configuration registers, request intake, engine and result register.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. A scan request debounces one key per clock
// through the key state memory, then drains; check and click requests read the event
// queue memory, with registered read data, and a click adds an evaluation state; an
// unused op code goes straight to done. A two entry request queue takes new requests
// while the engine works and while a result waits in the output register. The user
// must write configuration only while idle; the block itself does not enforce it.
module key_matrix_scan_debounce_events_top import kmsd_pkg::*; #(
  parameter int ROWS        = 8,
  parameter int COLS        = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], column_levels[9:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // key_found[0], key_index[6:1], queued_events[10:7]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg_r;
  logic req_valid, req_pop, res_valid, res_ready;
  req_t req;
  res_t res;
  logic out_valid_r;
  res_t out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_up   <= 16'd2;
      cfg_r.max_up   <= 16'd1000;
      cfg_r.min_down <= 16'd2;
      cfg_r.ev_mask  <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_UP:   cfg_r.min_up   <= cfg_wdata;
        REG_MAX_UP:   cfg_r.max_up   <= cfg_wdata;
        REG_MIN_DOWN: cfg_r.min_down <= cfg_wdata;
        REG_EV_MASK:  cfg_r.ev_mask  <= cfg_wdata[3:0];
      endcase
    end
  end

  kmsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[1:0]),
    .in_levels (in_tdata[9:2]),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  kmsd_back #(.ROWS(ROWS), .COLS(COLS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.queued, out_r.key, out_r.found};

endmodule
